// ===== hdl/stq_pkg.sv =====
`default_nettype none
package stq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int NUM_IDS       = 16;
    localparam int ID_W          = 4;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_CANCEL  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  event_id;
        logic [31:0] exec_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_id;
        logic [31:0] out_time;
        logic [4:0]  entry_count;
        logic        top_valid;
        logic [3:0]  top_id;
        logic [31:0] top_time;
    } t_out_item;

endpackage
`default_nettype wire

// ===== hdl/stq_slot_ram.sv =====
`default_nettype none
module stq_slot_ram #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF,
    parameter int WIDTH = stq_pkg::TIME_BITS_DEF + stq_pkg::ID_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/sorted_timer_event_queue_unit.sv =====
`default_nettype none
// channel | direction | payload              | handshake
// input   | in        | stq_pkg::t_in_item   | i_valid / o_stall
// output  | out       | stq_pkg::t_out_item  | o_valid / i_stall
//
// one transaction at a time; a walk step is a slot ram read, then a compare and write
// back. an error skips the walk and goes straight to the result; a walk may end in a
// slot write. reset clears the state, queued flags, count and output valid; the slot
// ram is not cleared.
// the result sits in an output register; a new item is taken while it waits, and the
// next result keeps the input stalled until the waiting one is taken.
module sorted_timer_event_queue_unit #(
    parameter int DEPTH     = stq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire stq_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output stq_pkg::t_out_item      o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = stq_pkg::ID_W;
    localparam int SW = TIME_BITS + IW;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_PUT, S_DONE} t_state;
    typedef enum logic [2:0] {M_OLD, M_TAKE, M_SHIFT, M_FRONT, M_BACK} t_mode;

    t_state r_state;
    t_mode  r_mode;
    logic [PW-1:0]        r_pos;
    logic [TIME_BITS-1:0] r_cur_time;
    logic [IW-1:0]        r_cur_id;
    logic [CW-1:0]        r_count;
    logic [stq_pkg::NUM_IDS-1:0] r_queued;
    logic [PW-1:0]        r_idpos [stq_pkg::NUM_IDS];
    logic [TIME_BITS-1:0] r_top_time;
    logic [IW-1:0]        r_top_id;
    logic [1:0]           r_status;
    logic [IW-1:0]        r_res_id;
    logic [31:0]          r_res_time;
    logic                 r_oval;
    stq_pkg::t_out_item   r_odata;

    logic [SW-1:0]        rdata;
    logic [TIME_BITS-1:0] rd_time;
    logic [IW-1:0]        rd_id;
    logic [PW-1:0]        rd_addr;
    logic                 wr_en;
    logic [SW-1:0]        wr_data;
    logic                 lt;
    logic                 gt;
    logic [CW:0]          pos_x;
    logic [CW:0]          cnt_x;
    logic [IW-1:0]        in_id;
    logic [PW-1:0]        in_pos;
    logic [TIME_BITS-1:0] in_time;

    assign rd_time = rdata[SW-1:IW];
    assign rd_id   = rdata[IW-1:0];
    assign lt      = r_cur_time < rd_time;
    assign gt      = r_cur_time > rd_time;
    assign pos_x   = (CW+1)'(r_pos);
    assign cnt_x   = (CW+1)'(r_count);
    assign in_id   = i_data.event_id;
    assign in_pos  = r_idpos[in_id];
    assign in_time = TIME_BITS'(i_data.exec_time);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_odata;

    always_comb begin
        case (r_mode)
            M_FRONT:        rd_addr = r_pos - PW'(1);
            M_BACK, M_SHIFT: rd_addr = r_pos + PW'(1);
            default:        rd_addr = r_pos;
        endcase
        wr_en = 1'b0;
        if (r_state == S_PUT) begin
            wr_en = 1'b1;
        end else if (r_state == S_EV) begin
            wr_en = (r_mode == M_SHIFT) || (r_mode == M_FRONT && lt)
                    || (r_mode == M_BACK && gt);
        end
        wr_data = (r_state == S_PUT) ? {r_cur_time, r_cur_id} : rdata;
    end

    stq_slot_ram #(.DEPTH(DEPTH), .WIDTH(SW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_pos),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // position table and cached slot 0 follow every slot write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_idpos[wr_data[IW-1:0]] <= r_pos;
            if (r_pos == '0) begin
                r_top_time <= wr_data[SW-1:IW];
                r_top_id   <= wr_data[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_OLD;
            r_count  <= '0;
            r_queued <= '0;
            r_oval   <= 1'b0;
        end else begin
            if (r_oval && !i_stall && r_state != S_DONE) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res_id   <= '0;
                        r_res_time <= '0;
                        r_cur_time <= in_time;
                        r_cur_id   <= in_id;
                        case (i_data.op)
                            stq_pkg::OP_ADD: begin
                                if (r_queued[in_id]) begin
                                    r_status <= stq_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end else if (r_count >= CW'(DEPTH)) begin
                                    r_status <= stq_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= stq_pkg::ST_OK;
                                    r_queued[in_id] <= 1'b1;
                                    r_count <= r_count + CW'(1);
                                    r_pos   <= PW'(r_count);
                                    r_mode  <= M_FRONT;
                                    r_state <= (r_count == '0) ? S_PUT : S_RD;
                                end
                            end
                            stq_pkg::OP_POP: begin
                                if (r_count == '0) begin
                                    r_status <= stq_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= stq_pkg::ST_OK;
                                    r_count <= r_count - CW'(1);
                                    r_pos   <= '0;
                                    r_mode  <= M_TAKE;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (!r_queued[in_id] || CW'(in_pos) >= r_count) begin
                                    r_status <= stq_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= stq_pkg::ST_OK;
                                    r_pos   <= in_pos;
                                    r_state <= S_RD;
                                    if (i_data.op == stq_pkg::OP_RESTART) begin
                                        r_mode <= M_OLD;
                                    end else begin
                                        r_mode  <= M_TAKE;
                                        r_count <= r_count - CW'(1);
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    case (r_mode)
                        M_TAKE: begin
                            r_res_id   <= rd_id;
                            r_res_time <= 32'(rd_time);
                            r_queued[rd_id] <= 1'b0;
                            if (pos_x < cnt_x) begin
                                r_mode  <= M_SHIFT;
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        M_SHIFT: begin
                            r_pos   <= r_pos + PW'(1);
                            r_state <= (pos_x + (CW+1)'(1) < cnt_x) ? S_RD : S_DONE;
                        end
                        M_OLD: begin
                            if (lt) begin
                                r_mode  <= M_FRONT;
                                r_state <= (r_pos == '0) ? S_PUT : S_RD;
                            end else begin
                                r_mode  <= M_BACK;
                                r_state <= (pos_x + (CW+1)'(1) < cnt_x) ? S_RD : S_PUT;
                            end
                        end
                        M_FRONT: begin
                            if (lt) begin
                                r_pos   <= r_pos - PW'(1);
                                r_state <= (r_pos == PW'(1)) ? S_PUT : S_RD;
                            end else begin
                                r_state <= S_PUT;
                            end
                        end
                        default: begin
                            if (gt) begin
                                r_pos   <= r_pos + PW'(1);
                                r_state <= (pos_x + (CW+1)'(2) < cnt_x) ? S_RD : S_PUT;
                            end else begin
                                r_state <= S_PUT;
                            end
                        end
                    endcase
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_oval || !i_stall) begin
                        r_oval <= 1'b1;
                        r_odata.status      <= r_status;
                        r_odata.out_id      <= r_res_id;
                        r_odata.out_time    <= r_res_time;
                        r_odata.entry_count <= 5'(r_count);
                        r_odata.top_valid   <= (r_count != '0);
                        r_odata.top_id      <= (r_count != '0) ? r_top_id : '0;
                        r_odata.top_time    <= (r_count != '0) ? 32'(r_top_time) : '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== test/sorted_timer_event_queue_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sorted_timer_event_queue_unit_tb;

    localparam int QDEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    stq_pkg::t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    stq_pkg::t_out_item o_data;

    sorted_timer_event_queue_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #4 i_clk = ~i_clk;

    // timer queue shadow
    logic [31:0] sh_time [QDEPTH];
    logic [3:0]  sh_id [QDEPTH];
    logic [3:0]  sh_pos [16];
    logic        sh_queued [16];
    int          sh_count;

    stq_pkg::t_out_item pending_results [$];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    logic [3:0]  pick_id;

    function automatic void swap_slots(int a, int b);
        logic [31:0] t;
        logic [3:0]  d;
        t = sh_time[a]; d = sh_id[a];
        sh_time[a] = sh_time[b]; sh_id[a] = sh_id[b];
        sh_time[b] = t; sh_id[b] = d;
        sh_pos[sh_id[a]] = a[3:0];
        sh_pos[sh_id[b]] = b[3:0];
    endfunction

    function automatic void remove_slot(int p, ref stq_pkg::t_out_item r);
        logic [3:0] d;
        d = sh_id[p];
        r.out_id = d;
        r.out_time = sh_time[p];
        while (p + 1 < sh_count) begin
            swap_slots(p, p + 1);
            p++;
        end
        sh_count--;
        sh_queued[d] = 1'b0;
    endfunction

    function automatic stq_pkg::t_out_item queue_apply(stq_pkg::t_in_item it);
        stq_pkg::t_out_item r;
        int p;
        logic [31:0] old;
        r = '0;
        case (it.op)
            stq_pkg::OP_ADD: begin
                if (sh_queued[it.event_id]) r.status = stq_pkg::ST_NOT_FOUND;
                else if (sh_count >= QDEPTH) r.status = stq_pkg::ST_FULL;
                else begin
                    p = sh_count;
                    sh_time[p] = it.exec_time;
                    sh_id[p] = it.event_id;
                    sh_pos[it.event_id] = p[3:0];
                    sh_queued[it.event_id] = 1'b1;
                    sh_count++;
                    while (p > 0 && sh_time[p] < sh_time[p-1]) begin
                        swap_slots(p, p - 1);
                        p--;
                    end
                end
            end
            stq_pkg::OP_POP: begin
                if (sh_count == 0) r.status = stq_pkg::ST_EMPTY;
                else remove_slot(0, r);
            end
            stq_pkg::OP_RESTART: begin
                if (!sh_queued[it.event_id]) r.status = stq_pkg::ST_NOT_FOUND;
                else begin
                    p = sh_pos[it.event_id];
                    old = sh_time[p];
                    sh_time[p] = it.exec_time;
                    if (it.exec_time < old) begin
                        while (p > 0 && sh_time[p] < sh_time[p-1]) begin
                            swap_slots(p, p - 1);
                            p--;
                        end
                    end else begin
                        while (p + 1 < sh_count && sh_time[p] > sh_time[p+1]) begin
                            swap_slots(p, p + 1);
                            p++;
                        end
                    end
                end
            end
            default: begin
                if (!sh_queued[it.event_id]) r.status = stq_pkg::ST_NOT_FOUND;
                else remove_slot(sh_pos[it.event_id], r);
            end
        endcase
        r.entry_count = sh_count[4:0];
        if (sh_count > 0) begin
            r.top_valid = 1'b1;
            r.top_id = sh_id[0];
            r.top_time = sh_time[0];
        end
        return r;
    endfunction

    task automatic send_event(stq_pkg::t_in_item it, bit has_fixed, stq_pkg::t_out_item fixed);
        stq_pkg::t_out_item r;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        r = queue_apply(it);
        if (has_fixed && r !== fixed) begin
            $display("%0t: typed-in row disagrees expected=%h predicted=%h", $time, fixed, r);
            n_errors++;
        end
        pending_results.push_back(has_fixed ? fixed : r);
    endtask

    function automatic stq_pkg::t_out_item mk(logic [1:0] st, logic [3:0] oid,
                                              logic [31:0] ot, int cnt, logic tv,
                                              logic [3:0] tid, logic [31:0] tt);
        stq_pkg::t_out_item r;
        r.status = st; r.out_id = oid; r.out_time = ot; r.entry_count = cnt[4:0];
        r.top_valid = tv; r.top_id = tid; r.top_time = tt;
        return r;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        stq_pkg::t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result actual=%h", $time, o_data);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_data.status !== e.status || o_data.out_id !== e.out_id ||
                    o_data.out_time !== e.out_time || o_data.entry_count !== e.entry_count ||
                    o_data.top_valid !== e.top_valid || o_data.top_id !== e.top_id ||
                    o_data.top_time !== e.top_time) begin
                    $display("%0t: mismatch expected=%h actual=%h", $time, e, o_data);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalling
    always @(posedge i_clk) begin
        i_stall <= hold_off || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("sorted_timer_event_queue_unit_tb failed");
            $finish;
        end
    end

    typedef struct {
        stq_pkg::t_in_item  stim;
        bit                 has_fixed;
        stq_pkg::t_out_item fixed;
    } t_row;

    t_row directed_rows [$];

    function automatic stq_pkg::t_in_item mkin(logic [1:0] op, logic [3:0] id,
                                               logic [31:0] t);
        stq_pkg::t_in_item it;
        it.op = op; it.event_id = id; it.exec_time = t;
        return it;
    endfunction

    function automatic stq_pkg::t_in_item random_event(int busy);
        stq_pkg::t_in_item it;
        int r;
        r = $urandom_range(99);
        it.event_id = 4'($urandom_range(15));
        case ($urandom_range(3))
            0: it.exec_time = $urandom();
            1: it.exec_time = $urandom_range(7);
            2: it.exec_time = 32'hFFFF_FFF8 | $urandom_range(7);
            default: it.exec_time = $urandom_range(63) << $urandom_range(26);
        endcase
        if (r < busy) it.op = stq_pkg::OP_ADD;
        else if (r < busy + 20) it.op = stq_pkg::OP_RESTART;
        else if (r < busy + 30) it.op = stq_pkg::OP_CANCEL;
        else it.op = stq_pkg::OP_POP;
        return it;
    endfunction

    initial begin
        t_row row;
        int ph;
        for (int k = 0; k < 16; k++) begin
            sh_queued[k] = 1'b0; sh_pos[k] = '0; sh_time[k] = '0; sh_id[k] = '0;
        end
        sh_count = 0;
        // directed rows: errors on empty queue, extremes, tie order, full
        row.has_fixed = 1;
        row.stim = mkin(stq_pkg::OP_POP, 4'd0, 32'd0);
        row.fixed = mk(stq_pkg::ST_EMPTY, '0, '0, 0, 1'b0, '0, '0);
        directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_CANCEL, 4'd5, 32'd0);
        row.fixed = mk(stq_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b0, '0, '0);
        directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_RESTART, 4'd9, 32'd7);
        row.fixed = mk(stq_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b0, '0, '0);
        directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_ADD, 4'd15, 32'hFFFF_FFFF);
        row.fixed = mk(stq_pkg::ST_OK, '0, '0, 1, 1'b1, 4'd15, 32'hFFFF_FFFF);
        directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_ADD, 4'd15, 32'd1);
        row.fixed = mk(stq_pkg::ST_NOT_FOUND, '0, '0, 1, 1'b1, 4'd15, 32'hFFFF_FFFF);
        directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_ADD, 4'd0, 32'd0);
        row.fixed = mk(stq_pkg::ST_OK, '0, '0, 2, 1'b1, 4'd0, 32'd0);
        directed_rows.push_back(row);
        row.has_fixed = 0;
        row.stim = mkin(stq_pkg::OP_ADD, 4'd3, 32'd0); directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_ADD, 4'd4, 32'h8000_0000); directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_RESTART, 4'd0, 32'hFFFF_FFFF); directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_RESTART, 4'd15, 32'd0); directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_CANCEL, 4'd4, 32'd0); directed_rows.push_back(row);
        row.stim = mkin(stq_pkg::OP_POP, 4'd0, 32'd0); directed_rows.push_back(row);
        for (int k = 0; k < 16; k++) begin
            row.stim = mkin(stq_pkg::OP_ADD, k[3:0], 32'h5555_5555 ^ (k * 32'h1111_1111));
            directed_rows.push_back(row);
        end
        row.stim = mkin(stq_pkg::OP_POP, 4'd0, 32'd0); directed_rows.push_back(row);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_event(directed_rows[k].stim, directed_rows[k].has_fixed,
                       directed_rows[k].fixed);
        // the queue is one short of full here: a queued id, then a free one to top it up
        send_event(mkin(stq_pkg::OP_ADD, 4'd0, 32'd3), 0, '0);
        pick_id = 4'd0;
        for (int k = 0; k < 16; k++) if (!sh_queued[k]) pick_id = k[3:0];
        send_event(mkin(stq_pkg::OP_ADD, pick_id, 32'd3), 0, '0);

        // long receiver hold-off while the sender keeps pushing
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 12; k++) send_event(random_event(40), 0, '0);
        join

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // add-heavy and pop-heavy stretches of 40 events alternate, to fill and drain
            for (int k = 0; k < 330; k++)
                send_event(random_event((k / 40) % 2 ? 20 : 60), 0, '0);
        end
        i_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("sorted_timer_event_queue_unit_tb passed");
        end else begin
            $display("sorted_timer_event_queue_unit_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
